### rtl/core/hsvrdc_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the hsv region dominant color block
// no dependencies

package hsvrdc_pkg;

    localparam int MAX_DIM     = 2048;
    localparam int POS_W       = $clog2(MAX_DIM);
    localparam int CFG_DIM_W   = 12;
    localparam int CFG_OFS_W   = 11;
    localparam int CMP_W       = (POS_W + 2 > 13) ? POS_W + 2 : 13;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 12;
    localparam int NUM_CLASSES = 10;
    localparam int CLS_W       = 4;
    localparam int CNT_W       = 22;
    localparam int Q_DEPTH     = 4;
    localparam int Q_PTR_W     = $clog2(Q_DEPTH);

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    localparam logic [CLS_W-1:0] CLS_BLACK  = 4'd0;
    localparam logic [CLS_W-1:0] CLS_GRAY   = 4'd1;
    localparam logic [CLS_W-1:0] CLS_WHITE  = 4'd2;
    localparam logic [CLS_W-1:0] CLS_RED    = 4'd3;
    localparam logic [CLS_W-1:0] CLS_ORANGE = 4'd4;
    localparam logic [CLS_W-1:0] CLS_YELLOW = 4'd5;
    localparam logic [CLS_W-1:0] CLS_GREEN  = 4'd6;
    localparam logic [CLS_W-1:0] CLS_CYAN   = 4'd7;
    localparam logic [CLS_W-1:0] CLS_BLUE   = 4'd8;
    localparam logic [CLS_W-1:0] CLS_PURPLE = 4'd9;
    localparam logic [CLS_W-1:0] CLS_LAST   = CLS_PURPLE;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_LEFT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_TOP      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_WIDTH    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_HEIGHT   = 3'd5;

    typedef struct packed {
        logic             hit;
        logic [CLS_W-1:0] cls;
        logic             last;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef struct packed {
        logic pop;
        logic pop_last;
        logic scan_busy;
    } t_back_status;

endpackage

### rtl/core/hsvrdc_front.sv
`timescale 1ns / 1ps
// front end: config registers, pixel position tracking, box test and classification
// depends on hsvrdc_pkg

module hsvrdc_front import hsvrdc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    input  logic                  i_q_full,
    input  logic [7:0]            i_hue,
    input  logic [7:0]            i_saturation,
    input  logic [7:0]            i_brightness,
    output logic                  o_in_ready,
    output logic                  o_push,
    output t_item                 o_item
);

    localparam logic [CMP_W-1:0] DIM_MAX = CMP_W'(MAX_DIM);
    localparam logic [CMP_W-1:0] DIM_ONE = CMP_W'(1);

    logic [CFG_DIM_W-1:0] r_image_width, r_image_height, r_box_width, r_box_height;
    logic [CFG_OFS_W-1:0] r_box_left, r_box_top;
    logic [POS_W-1:0]     r_col, r_row;

    logic [CMP_W-1:0] w_width, w_height, w_col, w_row, w_col_inc, w_row_inc;
    logic [CMP_W-1:0] w_row_lo, w_row_hi, w_col_lo, w_col_hi;
    logic             w_in_box, w_col_end, w_row_end, w_hit;
    logic [CLS_W-1:0] w_cls;

    function automatic logic [CMP_W-1:0] clamp_dim(input logic [CFG_DIM_W-1:0] v);
        logic [CMP_W-1:0] x;
        x = CMP_W'(v);
        if (x < DIM_ONE) begin
            return DIM_ONE;
        end else if (x > DIM_MAX) begin
            return DIM_MAX;
        end
        return x;
    endfunction

    always_comb begin
        w_hit = 1'b1;
        w_cls = CLS_BLACK;
        if (i_hue > 8'd180) begin
            w_hit = 1'b0;
        end else if (i_brightness <= 8'd46) begin
            w_cls = CLS_BLACK;
        end else if (i_saturation <= 8'd43 && i_brightness <= 8'd220) begin
            w_cls = CLS_GRAY;
        end else if (i_saturation <= 8'd30 && i_brightness >= 8'd221) begin
            w_cls = CLS_WHITE;
        end else if (i_saturation < 8'd43) begin
            w_hit = 1'b0;
        end else if (i_hue <= 8'd10 || i_hue >= 8'd156) begin
            w_cls = CLS_RED;
        end else if (i_hue <= 8'd25) begin
            w_cls = CLS_ORANGE;
        end else if (i_hue <= 8'd34) begin
            w_cls = CLS_YELLOW;
        end else if (i_hue <= 8'd77) begin
            w_cls = CLS_GREEN;
        end else if (i_hue <= 8'd99) begin
            w_cls = CLS_CYAN;
        end else if (i_hue <= 8'd124) begin
            w_cls = CLS_BLUE;
        end else begin
            w_cls = CLS_PURPLE;
        end
    end

    always_comb begin
        w_width   = clamp_dim(r_image_width);
        w_height  = clamp_dim(r_image_height);
        w_col     = CMP_W'(r_col);
        w_row     = CMP_W'(r_row);
        w_col_inc = w_col + DIM_ONE;
        w_row_inc = w_row + DIM_ONE;
        w_col_lo  = CMP_W'(r_box_left);
        w_col_hi  = CMP_W'(r_box_left) + CMP_W'(r_box_width);
        w_row_lo  = CMP_W'(r_box_top) + CMP_W'(r_box_height >> 1);
        w_row_hi  = CMP_W'(r_box_top) + CMP_W'(r_box_height);
        w_in_box  = (w_row >= w_row_lo) && (w_row < w_row_hi) &&
                    (w_col >= w_col_lo) && (w_col < w_col_hi);
        w_col_end = w_col_inc >= w_width;
        w_row_end = w_row_inc >= w_height;
    end

    assign o_in_ready  = !i_q_full;
    assign o_push      = i_in_valid && o_in_ready;
    assign o_item.hit  = w_in_box && w_hit;
    assign o_item.cls  = w_cls;
    assign o_item.last = w_col_end && w_row_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= CFG_DIM_W'(640);
            r_image_height <= CFG_DIM_W'(480);
            r_box_left     <= '0;
            r_box_top      <= '0;
            r_box_width    <= '0;
            r_box_height   <= '0;
            r_col          <= '0;
            r_row          <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data;
                    REG_IMAGE_HEIGHT: r_image_height <= i_cfg_data;
                    REG_BOX_LEFT:     r_box_left     <= i_cfg_data[CFG_OFS_W-1:0];
                    REG_BOX_TOP:      r_box_top      <= i_cfg_data[CFG_OFS_W-1:0];
                    REG_BOX_WIDTH:    r_box_width    <= i_cfg_data;
                    REG_BOX_HEIGHT:   r_box_height   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (o_push) begin
                if (w_col_end) begin
                    r_col <= '0;
                    if (w_row_end) begin
                        r_row <= '0;
                    end else begin
                        r_row <= w_row_inc[POS_W-1:0];
                    end
                end else begin
                    r_col <= w_col_inc[POS_W-1:0];
                end
            end
        end
    end

endmodule

### rtl/core/hsvrdc_queue.sv
`timescale 1ns / 1ps
// short item queue between the front end and the counter back end
// depends on hsvrdc_pkg

module hsvrdc_queue import hsvrdc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_item     i_item,
    input  logic      i_pop,
    output t_item     o_item,
    output t_q_status o_status
);

    t_item              r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [Q_PTR_W:0]   r_count;

    assign o_item         = r_mem[r_rd_ptr];
    assign o_status.full  = r_count == (Q_PTR_W+1)'(Q_DEPTH);
    assign o_status.empty = r_count == '0;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

### rtl/core/hsvrdc_back.sv
`timescale 1ns / 1ps
// back end: saturating class counters, frame snapshot, serial argmax and output register
// depends on hsvrdc_pkg

module hsvrdc_back import hsvrdc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_item            i_item,
    input  logic             i_q_empty,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output logic [CLS_W-1:0] o_dominant_class,
    output t_back_status     o_status
);

    logic [CNT_W-1:0] r_cnt  [NUM_CLASSES];
    logic [CNT_W-1:0] r_snap [NUM_CLASSES];
    logic [CNT_W-1:0] w_inc  [NUM_CLASSES];
    logic [CNT_W-1:0] r_best_val, w_cand;
    logic [CLS_W-1:0] r_idx, r_best, w_new_best, r_out_class;
    logic             r_scan, r_out_valid, w_pop, w_gt, w_out_free, w_finish;

    assign w_pop      = !i_q_empty && (!i_item.last || !r_scan);
    assign w_cand     = r_snap[r_idx];
    assign w_gt       = w_cand > r_best_val;
    assign w_new_best = w_gt ? r_idx : r_best;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_finish   = r_scan && (r_idx == CLS_LAST) && w_out_free;

    always_comb begin
        for (int i = 0; i < NUM_CLASSES; i++) begin
            w_inc[i] = r_cnt[i] + CNT_W'(i_item.hit && i_item.cls == CLS_W'(i) &&
                                        r_cnt[i] != CNT_MAX);
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_dominant_class   = r_out_class;
    assign o_status.pop       = w_pop;
    assign o_status.pop_last  = w_pop && i_item.last;
    assign o_status.scan_busy = r_scan;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CLASSES; i++) begin
                r_cnt[i]  <= '0;
                r_snap[i] <= '0;
            end
            r_scan      <= 1'b0;
            r_idx       <= '0;
            r_best      <= '0;
            r_best_val  <= '0;
            r_out_valid <= 1'b0;
            r_out_class <= '0;
        end else begin
            if (w_finish) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_pop) begin
                for (int i = 0; i < NUM_CLASSES; i++) begin
                    r_cnt[i] <= i_item.last ? '0 : w_inc[i];
                end
                if (i_item.last) begin
                    for (int i = 0; i < NUM_CLASSES; i++) begin
                        r_snap[i] <= w_inc[i];
                    end
                    r_scan     <= 1'b1;
                    r_idx      <= CLS_W'(1);
                    r_best     <= CLS_BLACK;
                    r_best_val <= w_inc[0];
                end
            end
            if (r_scan) begin
                if (r_idx == CLS_LAST) begin
                    if (w_out_free) begin
                        r_scan      <= 1'b0;
                        r_out_class <= w_new_best;
                    end
                end else begin
                    r_idx      <= r_idx + 1'b1;
                    r_best     <= w_new_best;
                    r_best_val <= w_gt ? w_cand : r_best_val;
                end
            end
        end
    end

endmodule

### rtl/core/hsv_region_dominant_color_top.sv
`timescale 1ns / 1ps
// hsv region dominant color, top level; depends on hsvrdc_pkg, front, queue, back
// throughput: one pixel item per cycle, except while a frame-end item waits for a busy argmax scan
// path from the last pixel of a frame to result valid: queue, counter update and snapshot,
// nine-step serial argmax over the class counters, output register
// frame ends that arrive while the argmax scan is still busy stall the input once the queue fills
// reset: synchronous active low; config to defaults, counters, position and queue cleared

module hsv_region_dominant_color_top import hsvrdc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [7:0]            i_hue,
    input  logic [7:0]            i_saturation,
    input  logic [7:0]            i_brightness,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [CLS_W-1:0]      o_dominant_class
);

    t_item        w_push_item, w_head_item;
    t_q_status    w_q_status;
    t_back_status w_back_status;
    logic         w_push;

    assign o_cfg_ready = 1'b1;

    hsvrdc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid && o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .i_q_full     (w_q_status.full),
        .i_hue        (i_hue),
        .i_saturation (i_saturation),
        .i_brightness (i_brightness),
        .o_in_ready   (o_in_ready),
        .o_push       (w_push),
        .o_item       (w_push_item)
    );

    hsvrdc_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_item   (w_push_item),
        .i_pop    (w_back_status.pop),
        .o_item   (w_head_item),
        .o_status (w_q_status)
    );

    hsvrdc_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_item           (w_head_item),
        .i_q_empty        (w_q_status.empty),
        .i_out_ready      (i_out_ready),
        .o_out_valid      (o_out_valid),
        .o_dominant_class (o_dominant_class),
        .o_status         (w_back_status)
    );

`ifndef SYNTH
    a_queue_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_q_status.full && w_q_status.empty))
        else $error("queue full and empty at once");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_back_status.pop |-> !w_q_status.empty)
        else $error("pop from empty queue");

    a_last_scan_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_back_status.pop_last |=> w_back_status.scan_busy)
        else $error("frame end did not start the argmax scan");

    a_class_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_dominant_class <= CLS_LAST)
        else $error("dominant class out of range");
`endif

endmodule
